@@ hw/rtl/page_lz_decompressor_assert.svh @@
// Assertion shorthands for the checker file of the page decompressor.
`ifndef PAGE_LZ_DECOMPRESSOR_ASSERT_SVH
`define PAGE_LZ_DECOMPRESSOR_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PLZD_AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PLZD_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/plzd_pkg.sv @@
`default_nettype none

package plzd_pkg;

    // Default geometry
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int OUT_LANES_DEF  = 8;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 12;
    localparam int LEN_W      = 9;
    localparam int OUT_BYTES_W = 64;
    localparam int COUNT_W    = 4;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 2;

    // Stream constants
    localparam logic [7:0] TOKEN_RESET  = 8'd103;
    localparam logic [2:0] CODE_EXT     = 3'd7;
    localparam int         LEN_BASE     = 4;
    localparam int         LEN_BASE_EXT = 11;

    // Parse phase of the compressed stream
    typedef enum logic [3:0] {
        PH_LIT   = 4'b0001,
        PH_TOKEN = 4'b0010,
        PH_OFFS  = 4'b0100,
        PH_EXTRA = 4'b1000
    } phase_t;

    // Copy sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LIT   = 6'b000010,
        S_CHECK = 6'b000100,
        S_RD    = 6'b001000,
        S_WR    = 6'b010000,
        S_EMIT  = 6'b100000
    } seq_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/plzd_hist.sv @@
`default_nettype none

// Page history: one write port, one read port with registered data.
module plzd_hist #(
    parameter int DEPTH = plzd_pkg::PAGE_BYTES_DEF,
    parameter int AW    = $clog2(plzd_pkg::PAGE_BYTES_DEF)
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [plzd_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [plzd_pkg::BYTE_W-1:0] rd_data
);
    import plzd_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Store a written byte
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read word, hold it between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/page_lz_decompressor.sv @@
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    tdata[7:0] compressed byte
// m_        out        m_tvalid/m_tready    tdata, tlast = run_last, tuser flags
// cfg_      in         cfg_we               cfg_wdata = token byte
//
// A token byte, or a byte after a token that opens a copy, is taken without leaving S_IDLE.
// A literal is accepted, then S_LIT writes it to the history and loads the result.
// A copy passes S_CHECK, then S_RD and S_WR for each copied byte and S_EMIT per output word:
// the history read is registered, and each byte is written back before the next read.
// Reset is synchronous and active low; the history memory is not cleared.
// A stalled output holds the sequencer in its check, literal or emit state.
module page_lz_decompressor #(
    parameter int PAGE_BYTES = plzd_pkg::PAGE_BYTES_DEF,
    parameter int OUT_LANES  = plzd_pkg::OUT_LANES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [plzd_pkg::BYTE_W-1:0]    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [plzd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [plzd_pkg::M_TDATA_W-1:0]      m_tdata,   // [63:0] out_bytes, [67:64] byte_count
    output logic                                m_tlast,
    output logic [plzd_pkg::M_TUSER_W-1:0]      m_tuser    // [0] page_done, [1] bad_offset
);
    import plzd_pkg::*;

    localparam int POS_W  = $clog2(PAGE_BYTES);
    localparam int ROOM_W = POS_W + 1;
    localparam int LIDX_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
    localparam int CNT_LW = $clog2(OUT_LANES + 1);

    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;

    logic [BYTE_W-1:0]   token_reg;
    logic [POS_W-1:0]    wp_reg, wp_next;
    logic [2:0]          code_reg, code_next;
    logic [OFFSET_W-1:0] src_reg, src_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    remain_reg, remain_next;
    logic [POS_W-1:0]    rd_addr_reg, rd_addr_next;
    logic [BYTE_W-1:0]   lit_reg, lit_next;
    logic [OUT_LANES-1:0][BYTE_W-1:0] acc_reg, acc_next;
    logic [CNT_LW-1:0]   lane_reg, lane_next;
    logic                chunk_last_reg, chunk_last_next;
    logic                chunk_done_reg, chunk_done_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_BYTES_W-1:0] m_bytes_reg, m_bytes_next;
    logic [COUNT_W-1:0]     m_count_reg, m_count_next;
    logic                   m_last_reg, m_last_next;
    logic                   m_done_reg, m_done_next;
    logic                   m_bad_reg, m_bad_next;

    logic                hist_we;
    logic [BYTE_W-1:0]   hist_wdata;
    logic                hist_re;
    logic [BYTE_W-1:0]   hist_rdata;

    logic                in_acc;
    logic                out_free;
    logic                pos_wrap;
    logic [POS_W-1:0]    pos_inc;
    logic                src_bad;
    logic [ROOM_W-1:0]   room;
    logic                chunk_end;

    plzd_hist #(
        .DEPTH (PAGE_BYTES),
        .AW    (POS_W)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (wp_reg),
        .wr_data (hist_wdata),
        .rd_en   (hist_re),
        .rd_addr (rd_addr_reg),
        .rd_data (hist_rdata)
    );

    // Handshake terms
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Position counter with page wrap, source check and remaining room
    assign pos_wrap  = (wp_reg == POS_W'(PAGE_BYTES - 1));
    assign pos_inc   = pos_wrap ? '0 : wp_reg + POS_W'(1);
    assign src_bad   = (src_reg >= OFFSET_W'(wp_reg));
    assign room      = ROOM_W'(PAGE_BYTES) - ROOM_W'(wp_reg);
    assign chunk_end = (lane_reg == CNT_LW'(OUT_LANES - 1)) || (remain_reg == LEN_W'(1));

    assign hist_re = (state_reg == S_RD);

    // Parser and copy sequencer
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        wp_next         = wp_reg;
        code_next       = code_reg;
        src_next        = src_reg;
        len_next        = len_reg;
        remain_next     = remain_reg;
        rd_addr_next    = rd_addr_reg;
        lit_next        = lit_reg;
        acc_next        = acc_reg;
        lane_next       = lane_reg;
        chunk_last_next = chunk_last_reg;
        chunk_done_next = chunk_done_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_bytes_next    = m_bytes_reg;
        m_count_next    = m_count_reg;
        m_last_next     = m_last_reg;
        m_done_next     = m_done_reg;
        m_bad_next      = m_bad_reg;
        hist_we         = 1'b0;
        hist_wdata      = lit_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (phase_reg)
                        PH_LIT: begin
                            if (s_tdata == token_reg) begin
                                phase_next = PH_TOKEN;
                            end else begin
                                lit_next   = s_tdata;
                                state_next = S_LIT;
                            end
                        end
                        PH_TOKEN: begin
                            if (s_tdata == token_reg) begin
                                phase_next = PH_LIT;
                                lit_next   = token_reg;
                                state_next = S_LIT;
                            end else begin
                                code_next  = s_tdata[6:4];
                                src_next   = {s_tdata[3:0], 8'h00};
                                phase_next = PH_OFFS;
                            end
                        end
                        PH_OFFS: begin
                            src_next = {src_reg[OFFSET_W-1:8], s_tdata};
                            if (code_reg == CODE_EXT) begin
                                phase_next = PH_EXTRA;
                            end else begin
                                phase_next = PH_LIT;
                                len_next   = LEN_W'(LEN_BASE) + LEN_W'(code_reg);
                                state_next = S_CHECK;
                            end
                        end
                        PH_EXTRA: begin
                            phase_next = PH_LIT;
                            len_next   = LEN_W'(LEN_BASE_EXT) + LEN_W'(s_tdata);
                            state_next = S_CHECK;
                        end
                        default: phase_next = PH_LIT;
                    endcase
                end
            end
            S_LIT: begin
                // Write the literal and hand it out together
                if (out_free) begin
                    hist_we      = 1'b1;
                    hist_wdata   = lit_reg;
                    wp_next      = pos_inc;
                    m_valid_next = 1'b1;
                    m_bytes_next = OUT_BYTES_W'(lit_reg);
                    m_count_next = COUNT_W'(1);
                    m_last_next  = 1'b1;
                    m_done_next  = pos_wrap;
                    m_bad_next   = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_CHECK: begin
                if (src_bad) begin
                    // Drop the copy, report the error word
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_bytes_next = '0;
                        m_count_next = '0;
                        m_last_next  = 1'b1;
                        m_done_next  = 1'b0;
                        m_bad_next   = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    // Clip at page end and start reading the source
                    remain_next  = (room < ROOM_W'(len_reg)) ? LEN_W'(room) : len_reg;
                    rd_addr_next = POS_W'(src_reg);
                    acc_next     = '0;
                    lane_next    = '0;
                    state_next   = S_RD;
                end
            end
            S_RD: begin
                state_next = S_WR;
            end
            S_WR: begin
                // Write back the byte just read and gather it into the word
                hist_we                        = 1'b1;
                hist_wdata                     = hist_rdata;
                wp_next                        = pos_inc;
                acc_next[lane_reg[LIDX_W-1:0]] = hist_rdata;
                lane_next                      = lane_reg + CNT_LW'(1);
                remain_next                    = remain_reg - LEN_W'(1);
                rd_addr_next                   = rd_addr_reg + POS_W'(1);
                chunk_last_next                = (remain_reg == LEN_W'(1));
                chunk_done_next                = pos_wrap;
                state_next                     = chunk_end ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_bytes_next = OUT_BYTES_W'(acc_reg);
                    m_count_next = COUNT_W'(lane_reg);
                    m_last_next  = chunk_last_reg;
                    m_done_next  = chunk_done_reg;
                    m_bad_next   = 1'b0;
                    acc_next     = '0;
                    lane_next    = '0;
                    state_next   = chunk_last_reg ? S_IDLE : S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_LIT;
            token_reg   <= TOKEN_RESET;
            wp_reg      <= '0;
            code_reg    <= '0;
            src_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            wp_reg      <= wp_next;
            code_reg    <= code_next;
            src_reg     <= src_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                token_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        len_reg        <= len_next;
        remain_reg     <= remain_next;
        rd_addr_reg    <= rd_addr_next;
        lit_reg        <= lit_next;
        acc_reg        <= acc_next;
        lane_reg       <= lane_next;
        chunk_last_reg <= chunk_last_next;
        chunk_done_reg <= chunk_done_next;
        m_bytes_reg    <= m_bytes_next;
        m_count_reg    <= m_count_next;
        m_last_reg     <= m_last_next;
        m_done_reg     <= m_done_next;
        m_bad_reg      <= m_bad_next;
    end

    // Output word
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_BYTES_W - COUNT_W){1'b0}}, m_count_reg, m_bytes_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_bad_reg, m_done_reg};

endmodule

`default_nettype wire

@@ hw/rtl/page_lz_decompressor_checker.sv @@
`default_nettype none

`include "page_lz_decompressor_assert.svh"

// Port-level checks on the result stream of the page decompressor.
module page_lz_decompressor_checker #(
    parameter int OUT_LANES = plzd_pkg::OUT_LANES_DEF
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [plzd_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast,
    input wire logic [plzd_pkg::M_TUSER_W-1:0] m_tuser
);
    import plzd_pkg::*;

    // Hold a stalled word
    `PLZD_AST_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled word changed")
    // Error word is empty and ends the run
    `PLZD_AST_SAME(a_bad, m_tvalid && m_tuser[1], m_tdata[67:64] == 4'd0 && m_tdata[63:0] == 64'd0 && m_tlast && !m_tuser[0], "malformed error word")
    // Non-error words carry between one and OUT_LANES bytes
    `PLZD_AST_SAME(a_count, m_tvalid && !m_tuser[1], m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= COUNT_W'(OUT_LANES), "bad byte count")
    // The page end always closes a run
    `PLZD_AST_SAME(a_done, m_tvalid && m_tuser[0], m_tlast, "page end inside a run")

endmodule

bind page_lz_decompressor page_lz_decompressor_checker #(
    .OUT_LANES (OUT_LANES)
) u_checker (.*);

`default_nettype wire
